### sv/pidsr_pkg.sv
// pidsr_pkg: shared types and constants for the pid speed regulator
// no dependencies; imported by pidsr_mac and pid_speed_regulator
package pidsr_pkg;

  localparam int GAIN_W     = 16;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = GAIN_W / DIGIT_W;
  localparam int INTEG_W    = 40;
  // wide enough for ki*integral plus the other two products
  localparam int SUM_W      = 58;
  localparam int DRIVE_W    = 16;
  localparam int CLAMP_W    = 2;
  localparam int REG_IDX_W  = 2;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 16'hFF00;

  localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  localparam logic [CLAMP_W-1:0] CLAMP_NONE = 2'd0;
  localparam logic [CLAMP_W-1:0] CLAMP_HIGH = 2'd1;
  localparam logic [CLAMP_W-1:0] CLAMP_LOW  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_KP         = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI         = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_KD_OVER_DT = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_DT  = 2'd3;

  localparam logic [GAIN_W-1:0] KP_RESET         = 16'd4096;
  localparam logic [GAIN_W-1:0] KI_RESET         = 16'd410;
  localparam logic [GAIN_W-1:0] KD_OVER_DT_RESET = 16'd410;
  localparam logic [GAIN_W-1:0] PERIOD_DT_RESET  = 16'd410;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_cmd_t;

endpackage

### sv/pidsr_mac.sv
// pidsr_mac: digit-serial multiply-accumulate, one 4-bit gain digit per cycle
// depends on pidsr_pkg
module pidsr_mac import pidsr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  mac_cmd_t                cmd,
  input  logic signed [SUM_W-1:0] operand,
  input  logic [GAIN_W-1:0]       gain,
  output logic signed [SUM_W-1:0] acc,
  output logic                    done
);

  localparam int CNT_W = $clog2(NUM_DIGITS + 1);

  logic signed [SUM_W-1:0] mcand;
  logic [GAIN_W-1:0]       mplier;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] partial;

  // signed multiplicand times one unsigned digit
  assign partial = SUM_W'(mcand * $signed({1'b0, mplier[DIGIT_W-1:0]}));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (cmd.start) begin
      mcand  <= operand;
      mplier <= gain;
      count  <= CNT_W'(NUM_DIGITS);
      done   <= 1'b0;
      if (cmd.clear) begin
        acc <= '0;
      end
    end else if (count != '0) begin
      acc    <= acc + partial;
      mcand  <= mcand <<< DIGIT_W;
      mplier <= mplier >> DIGIT_W;
      count  <= count - 1'b1;
      done   <= (count == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> (count == '0))
    else $error("mac started while a product was still running");

  a_done_after_last: assert property (@(posedge clk) disable iff (rst)
    done |-> (count == '0) && ($past(count) == CNT_W'(1)))
    else $error("mac done without finishing the last digit");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("mac done held longer than one cycle");

endmodule

### sv/pid_speed_regulator.sv
// pid_speed_regulator: fixed-point pid speed controller with anti-windup
// depends on pidsr_pkg and pidsr_mac
//
//   channel  handshake              payload
//   in       in_valid / in_stall    target_value, measured_value, run_enable
//   out      out_valid / out_stall  drive, clamp_state
//   cfg      cfg_write              cfg_index, cfg_data
//
// an enabled item runs four products through one shared mac, four gain digits
// each, between load and handoff steps, before the next item is accepted. a
// disabled item gives no result.
// rst is synchronous and restores the gains and clears integral and previous error.
// a stalled result waits in the output register; the next item is taken
// meanwhile and only its final step waits for the register to free up.
module pid_speed_regulator import pidsr_pkg::*; #(
  parameter int VALUE_WIDTH    = 24,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] target_value,
  input  logic [VALUE_WIDTH-1:0] measured_value,
  input  logic                   run_enable,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DRIVE_W-1:0]     drive,
  output logic [CLAMP_W-1:0]     clamp_state,
  input  logic                   cfg_write,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data
);

  localparam int ERR_W  = VALUE_WIDTH + 1;
  localparam int DIFF_W = VALUE_WIDTH + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_DT, S_CAND, S_KP, S_KI, S_KD, S_FINAL
  } state_t;

  state_t state;

  logic [GAIN_W-1:0] kp;
  logic [GAIN_W-1:0] ki;
  logic [GAIN_W-1:0] kd_over_dt;
  logic [GAIN_W-1:0] period_dt;

  logic signed [INTEG_W-1:0] integral_sum;
  logic signed [ERR_W-1:0]   previous_error;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W-1:0] cand;

  mac_cmd_t                mac_cmd;
  logic signed [SUM_W-1:0] mac_operand;
  logic [GAIN_W-1:0]       mac_gain;
  logic signed [SUM_W-1:0] mac_acc;
  logic                    mac_done;

  logic signed [ERR_W-1:0]   err_in;
  logic signed [DIFF_W-1:0]  err_diff;
  logic signed [SUM_W-1:0]   scaled;
  logic signed [SUM_W-1:0]   cand_sum;
  logic signed [INTEG_W-1:0] cand_next;
  logic [DRIVE_W-1:0]        drive_next;
  logic [CLAMP_W-1:0]        clamp_next;
  logic                      hold;
  logic                      in_accept;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign err_in = $signed({target_value[VALUE_WIDTH-1], target_value})
                - $signed({measured_value[VALUE_WIDTH-1], measured_value});

  assign err_diff = $signed({err[ERR_W-1], err})
                  - $signed({previous_error[ERR_W-1], previous_error});

  // floor shift of whatever the mac last produced
  assign scaled = mac_acc >>> GAIN_FRAC_BITS;

  // candidate integral with saturation to the integrator width
  assign cand_sum = $signed({{(SUM_W-INTEG_W){integral_sum[INTEG_W-1]}}, integral_sum})
                  + scaled;

  always_comb begin
    if ((&cand_sum[SUM_W-1:INTEG_W-1]) || !(|cand_sum[SUM_W-1:INTEG_W-1])) begin
      cand_next = cand_sum[INTEG_W-1:0];
    end else if (cand_sum[SUM_W-1]) begin
      cand_next = INTEG_MIN;
    end else begin
      cand_next = INTEG_MAX;
    end
  end

  // output clamp and anti-windup decision
  always_comb begin
    priority if (scaled > $signed({{(SUM_W-DRIVE_W){1'b0}}, DRIVE_MAX})) begin
      drive_next = DRIVE_MAX;
      clamp_next = CLAMP_HIGH;
      hold       = !err[ERR_W-1] && (|err);
    end else if (scaled[SUM_W-1]) begin
      drive_next = '0;
      clamp_next = CLAMP_LOW;
      hold       = err[ERR_W-1];
    end else begin
      drive_next = scaled[DRIVE_W-1:0];
      clamp_next = CLAMP_NONE;
      hold       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kp         <= KP_RESET;
      ki         <= KI_RESET;
      kd_over_dt <= KD_OVER_DT_RESET;
      period_dt  <= PERIOD_DT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KP:         kp         <= cfg_data;
        REG_KI:         ki         <= cfg_data;
        REG_KD_OVER_DT: kd_over_dt <= cfg_data;
        REG_PERIOD_DT:  period_dt  <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      mac_cmd        <= '0;
      integral_sum   <= '0;
      previous_error <= '0;
    end else begin
      // the final step reloads the register itself when it frees up
      if (out_valid && !out_stall && state != S_FINAL) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            err <= err_in;
            if (run_enable) begin
              mac_cmd     <= '{start: 1'b1, clear: 1'b1};
              mac_operand <= SUM_W'(err_in);
              mac_gain    <= period_dt;
              state       <= S_DT;
            end else begin
              integral_sum   <= '0;
              previous_error <= err_in;
            end
          end
        end
        S_DT: begin
          mac_cmd.start <= 1'b0;
          if (mac_done) begin
            state <= S_CAND;
          end
        end
        S_CAND: begin
          cand        <= cand_next;
          mac_cmd     <= '{start: 1'b1, clear: 1'b1};
          mac_operand <= SUM_W'(err);
          mac_gain    <= kp;
          state       <= S_KP;
        end
        S_KP: begin
          if (mac_done) begin
            mac_cmd     <= '{start: 1'b1, clear: 1'b0};
            mac_operand <= SUM_W'(cand);
            mac_gain    <= ki;
            state       <= S_KI;
          end else begin
            mac_cmd.start <= 1'b0;
          end
        end
        S_KI: begin
          if (mac_done) begin
            mac_cmd     <= '{start: 1'b1, clear: 1'b0};
            mac_operand <= SUM_W'(err_diff);
            mac_gain    <= kd_over_dt;
            state       <= S_KD;
          end else begin
            mac_cmd.start <= 1'b0;
          end
        end
        S_KD: begin
          mac_cmd.start <= 1'b0;
          if (mac_done) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          // wait until the previous result has left the output register
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            drive          <= drive_next;
            clamp_state    <= clamp_next;
            integral_sum   <= hold ? integral_sum : cand;
            previous_error <= err;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pidsr_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .cmd     (mac_cmd),
    .operand (mac_operand),
    .gain    (mac_gain),
    .acc     (mac_acc),
    .done    (mac_done)
  );

  a_result_from_final: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINAL))
    else $error("result raised outside the final step");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive <= DRIVE_MAX) && (clamp_state != 2'd3))
    else $error("drive or clamp state out of range");

  a_clamp_high_drive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clamp_state == CLAMP_HIGH) |-> (drive == DRIVE_MAX))
    else $error("high clamp without full drive");

  a_disabled_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && !run_enable) |=> (integral_sum == '0) && (state == S_IDLE))
    else $error("disabled item did not clear the integral");

endmodule
